>>> src/held_command_release_table_macros.svh
// ---------------------------------------------------------------------------
// Held command release table: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HELD_COMMAND_RELEASE_TABLE_MACROS_SVH
`define HELD_COMMAND_RELEASE_TABLE_MACROS_SVH

// same-cycle implication
`define HCRT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hcrt_pkg.sv
// ---------------------------------------------------------------------------
// Held command release table: package
// Shared types, codes and constants.
// ---------------------------------------------------------------------------
package hcrt_pkg;

    localparam int CMD_W        = 16;
    localparam int AGE_W        = 16;
    localparam int TIME_W       = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int COUNT_W      = $clog2(RESULT_LIMIT + 1);

    localparam logic [15:0] MIN_HOLD_RESET = 16'd180;
    localparam logic [15:0] MAX_HOLD_RESET = 16'd4000;

    localparam logic EV_BEGIN = 1'b0;
    localparam logic EV_END   = 1'b1;

    localparam logic REG_MIN_HOLD = 1'b0;
    localparam logic REG_MAX_HOLD = 1'b1;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PULSE   = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_BEGIN,
        ST_SWEEP,
        ST_FULL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [AGE_W-1:0] age;
        logic             down;
    } entry_t;

    typedef struct packed {
        action_t           act;
        logic [CMD_W-1:0]  key;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] min_hold;
        logic [TIME_W-1:0] max_hold;
        logic              hit;
        logic              claimed;
        logic              room;
    } head_ctrl_t;

    typedef struct packed {
        entry_t           entry;
        logic             emit;
        logic [CMD_W-1:0] emit_cmd;
        logic             claim;
    } head_res_t;

endpackage

>>> src/hcrt_cell.sv
// ---------------------------------------------------------------------------
// Held command release table: storage cell
// Holds one entry, passes it to its neighbour on each shift, flags a match.
// ---------------------------------------------------------------------------
module hcrt_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  hcrt_pkg::entry_t         entry_in,
    input  logic [hcrt_pkg::CMD_W-1:0] key,
    output hcrt_pkg::entry_t         entry,
    output logic                     match
);

    hcrt_pkg::entry_t entry_reg;
    hcrt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign match = (entry_reg.cmd == key);

endmodule

>>> src/hcrt_head.sv
// ---------------------------------------------------------------------------
// Held command release table: update head
// Applies the current operation to the entry leaving the front of the ring.
// ---------------------------------------------------------------------------
module hcrt_head
(
    input  hcrt_pkg::head_ctrl_t ctrl,
    input  hcrt_pkg::entry_t     entry_in,
    output hcrt_pkg::head_res_t  res
);

    logic [hcrt_pkg::AGE_W:0]   age_sum;
    logic [hcrt_pkg::AGE_W-1:0] age_sat;
    logic                       expire;

    assign age_sum = {1'b0, entry_in.age} + {1'b0, ctrl.elapsed};
    assign age_sat = age_sum[hcrt_pkg::AGE_W] ? '1 : age_sum[hcrt_pkg::AGE_W-1:0];
    assign expire  = ctrl.room
                     && (((age_sat >= ctrl.min_hold) && !entry_in.down)
                         || (age_sat >= ctrl.max_hold));

    always_comb
    begin
        res          = '0;
        res.entry    = entry_in;
        res.emit_cmd = entry_in.cmd;
        case (ctrl.act)
            hcrt_pkg::ACT_PRESS, hcrt_pkg::ACT_PULSE:
            begin
                if (entry_in.cmd == ctrl.key)
                begin
                    res.entry.age  = '0;
                    res.entry.down = (ctrl.act == hcrt_pkg::ACT_PRESS);
                end
                else if (!ctrl.hit && !ctrl.claimed && (entry_in.cmd == '0))
                begin
                    res.entry.cmd  = ctrl.key;
                    res.entry.age  = '0;
                    res.entry.down = (ctrl.act == hcrt_pkg::ACT_PRESS);
                    res.claim      = 1'b1;
                end
            end
            hcrt_pkg::ACT_RELEASE:
            begin
                if (entry_in.cmd == ctrl.key)
                begin
                    res.entry.down = 1'b0;
                end
            end
            default:
            begin
                if (entry_in.cmd != '0)
                begin
                    if (expire)
                    begin
                        res.entry = '0;
                        res.emit  = 1'b1;
                    end
                    else
                    begin
                        res.entry.age = age_sat;
                    end
                end
            end
        endcase
    end

endmodule

>>> src/held_command_release_table.sv
// ---------------------------------------------------------------------------
// Held command release table
// Table of held commands with age timers, released on ticks.
// ---------------------------------------------------------------------------
// The entries sit in a ring of cells that rotates past one update head, one
// entry per cycle while no result waits for room at the output side, so every
// press, release, pulse or tick passes through the match, begin, sweep, full
// and flush states from acceptance until the next item can be taken. Items
// with command id zero, other than ticks, are taken without leaving idle and
// give no result. Results leave in slot order, begin before end, with tlast
// on the final one of each item; an item's last result may still be waiting
// at the output when the next item is accepted.
module held_command_release_table
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] command_id, [31:16] elapsed_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] command_id_out
    output logic        m_axis_tuser,   // [0] event_res
    output logic        m_axis_tlast    // last
);

    localparam int STEP_W = $clog2(TABLE_ENTRIES);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TABLE_ENTRIES - 1);

    // configuration
    logic [15:0] min_hold_reg, min_hold_next;
    logic [15:0] max_hold_reg, max_hold_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        min_hold_next = min_hold_reg;
        max_hold_next = max_hold_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                hcrt_pkg::REG_MIN_HOLD: min_hold_next = pwdata[15:0];
                hcrt_pkg::REG_MAX_HOLD: max_hold_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            hcrt_pkg::REG_MIN_HOLD: prdata = {16'd0, min_hold_reg};
            hcrt_pkg::REG_MAX_HOLD: prdata = {16'd0, max_hold_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hold_reg <= hcrt_pkg::MIN_HOLD_RESET;
            max_hold_reg <= hcrt_pkg::MAX_HOLD_RESET;
        end
        else
        begin
            min_hold_reg <= min_hold_next;
            max_hold_reg <= max_hold_next;
        end
    end

    // control state
    hcrt_pkg::state_t  state_reg, state_next;
    hcrt_pkg::action_t act_reg, act_next;
    logic [15:0]       key_reg, key_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic              hit_reg, hit_next;
    logic              claimed_reg, claimed_next;
    logic [hcrt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // result staging
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_ev_reg, pend_ev_next;
    logic [15:0] pend_cmd_reg, pend_cmd_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_ev_reg, out_ev_next;
    logic [15:0] out_cmd_reg, out_cmd_next;
    logic        out_last_reg, out_last_next;

    hcrt_pkg::action_t in_act;
    logic              in_accept;
    logic              in_live;
    logic              hold_op;

    logic        emit_req;
    logic        emit_ev;
    logic [15:0] emit_cmd;
    logic        emit_ok;
    logic        out_free;
    logic        do_emit;
    logic        move;
    logic        advance;
    logic        flush_go;

    // ring of cells
    hcrt_pkg::entry_t          cell_entry [TABLE_ENTRIES];
    hcrt_pkg::entry_t          cell_in    [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  match_vec;
    hcrt_pkg::head_ctrl_t      head_ctrl;
    hcrt_pkg::head_res_t       head_res;
    logic                      shift;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        if (g == TABLE_ENTRIES - 1)
        begin : g_tail
            assign cell_in[g] = head_res.entry;
        end
        else
        begin : g_mid
            assign cell_in[g] = cell_entry[g+1];
        end

        hcrt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .entry_in (cell_in[g]),
            .key      (key_reg),
            .entry    (cell_entry[g]),
            .match    (match_vec[g])
        );
    end

    assign head_ctrl.act      = act_reg;
    assign head_ctrl.key      = key_reg;
    assign head_ctrl.elapsed  = elapsed_reg;
    assign head_ctrl.min_hold = min_hold_reg;
    assign head_ctrl.max_hold = max_hold_reg;
    assign head_ctrl.hit      = hit_reg;
    assign head_ctrl.claimed  = claimed_reg;
    assign head_ctrl.room     = (count_reg < hcrt_pkg::COUNT_W'(hcrt_pkg::RESULT_LIMIT));

    hcrt_head u_head
    (
        .ctrl     (head_ctrl),
        .entry_in (cell_entry[0]),
        .res      (head_res)
    );

    assign in_act    = hcrt_pkg::action_t'(s_axis_tuser);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_live   = (in_act == hcrt_pkg::ACT_TICK) || (s_axis_tdata[15:0] != 16'd0);
    assign hold_op   = (act_reg == hcrt_pkg::ACT_PRESS) || (act_reg == hcrt_pkg::ACT_PULSE);

    assign out_free = !out_valid_reg || m_axis_tready;
    assign emit_ok  = !pend_valid_reg || out_free;

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        emit_req      = 1'b0;
        emit_ev       = hcrt_pkg::EV_END;
        emit_cmd      = key_reg;
        advance       = 1'b0;
        flush_go      = 1'b0;
        unique case (state_reg)
            hcrt_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            hcrt_pkg::ST_BEGIN:
            begin
                emit_req = hold_op && !hit_reg;
                emit_ev  = hcrt_pkg::EV_BEGIN;
            end
            hcrt_pkg::ST_SWEEP:
            begin
                emit_req = head_res.emit;
                emit_cmd = head_res.emit_cmd;
                advance  = !head_res.emit || emit_ok;
            end
            hcrt_pkg::ST_FULL:
            begin
                emit_req = hold_op && !hit_reg && !claimed_reg;
            end
            hcrt_pkg::ST_FLUSH:
            begin
                flush_go = !pend_valid_reg || out_free;
            end
            default: ;
        endcase
    end

    assign shift   = advance;
    assign do_emit = emit_req && emit_ok;
    assign move    = pend_valid_reg
                     && (do_emit || ((state_reg == hcrt_pkg::ST_FLUSH) && out_free));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcrt_pkg::ST_IDLE:
            begin
                if (in_accept && in_live)
                begin
                    state_next = hcrt_pkg::ST_MATCH;
                end
            end
            hcrt_pkg::ST_MATCH:
            begin
                state_next = hcrt_pkg::ST_BEGIN;
            end
            hcrt_pkg::ST_BEGIN:
            begin
                if (!emit_req || emit_ok)
                begin
                    state_next = hcrt_pkg::ST_SWEEP;
                end
            end
            hcrt_pkg::ST_SWEEP:
            begin
                if (advance && (step_reg == STEP_LAST))
                begin
                    state_next = hcrt_pkg::ST_FULL;
                end
            end
            hcrt_pkg::ST_FULL:
            begin
                if (!emit_req || emit_ok)
                begin
                    state_next = hcrt_pkg::ST_FLUSH;
                end
            end
            hcrt_pkg::ST_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = hcrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcrt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        act_next        = act_reg;
        key_next        = key_reg;
        elapsed_next    = elapsed_reg;
        hit_next        = hit_reg;
        claimed_next    = claimed_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_cmd_next   = pend_cmd_reg;
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        out_cmd_next    = out_cmd_reg;
        out_last_next   = out_last_reg;

        if (in_accept)
        begin
            act_next     = in_act;
            key_next     = s_axis_tdata[15:0];
            elapsed_next = s_axis_tdata[31:16];
            claimed_next = 1'b0;
            count_next   = '0;
            step_next    = '0;
        end
        if (state_reg == hcrt_pkg::ST_MATCH)
        begin
            hit_next = |match_vec;
        end
        if (advance)
        begin
            step_next = step_reg + 1'b1;
            if (head_res.claim)
            begin
                claimed_next = 1'b1;
            end
            if (head_res.emit)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = pend_ev_reg;
            out_cmd_next   = pend_cmd_reg;
            out_last_next  = (state_reg == hcrt_pkg::ST_FLUSH);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (do_emit)
        begin
            pend_valid_next = 1'b1;
            pend_ev_next    = emit_ev;
            pend_cmd_next   = emit_cmd;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcrt_pkg::ST_IDLE;
            claimed_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            claimed_reg    <= claimed_next;
            hit_reg        <= hit_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        elapsed_reg  <= elapsed_next;
        pend_ev_reg  <= pend_ev_next;
        pend_cmd_reg <= pend_cmd_next;
        out_ev_reg   <= out_ev_next;
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_cmd_reg;
    assign m_axis_tuser  = out_ev_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> src/hcrt_checker.sv
// ---------------------------------------------------------------------------
// Held command release table: port checker
// Watches the top level's ports; bound to every instance of the top level.
// ---------------------------------------------------------------------------
`include "held_command_release_table_macros.svh"

module hcrt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic live_accept;
    logic idle_accept;

    assign live_accept = s_axis_tvalid && s_axis_tready
                         && ((s_axis_tuser == hcrt_pkg::ACT_TICK) || (s_axis_tdata[15:0] != 16'd0));
    assign idle_accept = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser != hcrt_pkg::ACT_TICK) && (s_axis_tdata[15:0] == 16'd0);

    `HCRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `HCRT_ASSERT_IMPL(a_cmd_nonzero, m_axis_tvalid, m_axis_tdata != 16'd0, "result carries command zero")
    `HCRT_ASSERT_NEXT(a_busy_after_live, live_accept, !s_axis_tready, "ready while an item is in work")
    `HCRT_ASSERT_NEXT(a_null_item_free, idle_accept, s_axis_tready, "item with no command held the input")

endmodule

bind held_command_release_table hcrt_checker u_hcrt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
